// ===== src/fixed_to_decimal_ascii_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point to decimal text core
// Clocked on clock, switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIXED_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define FIXED_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// cond holds in a cycle, so expr holds in the same cycle
`define FDA_ASSERT_SAME(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("fixed_to_decimal_ascii_core: same-cycle check failed");

// cond holds in a cycle, so expr holds in the next one
`define FDA_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("fixed_to_decimal_ascii_core: next-cycle check failed");

`endif

// ===== src/fda_pkg.sv =====
// ----------------------------------------------------------------------------
// fda_pkg
// Widths, constants and character codes of the decimal text core.
// ----------------------------------------------------------------------------
package fda_pkg;

   localparam int VALUE_W  = 32;
   localparam int CHAR_W   = 7;
   localparam int RSP_W    = 8;   // char_out filled up to a whole byte
   localparam int WORK_W   = 20;  // holds 999999 and the integer part
   localparam int QUO_W    = 17;
   localparam int DIGIT_W  = 4;
   localparam int FRAC_DIG = 6;
   localparam int INT_DIG  = 5;   // magnitude below 2^31 + 1 gives at most 32768

   localparam logic [19:0] FRAC_SCALE = 20'd1000000;
   // x / 10 == (x * RECIP_TEN) >> RECIP_SHIFT, exact for every x below 2^20
   localparam logic [19:0] RECIP_TEN   = 20'hCCCCD;
   localparam int          RECIP_SHIFT = 23;

   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

endpackage

// ===== src/fixed_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_core
// Formats a signed 16.16 fixed-point value as decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one signed 16.16 value per transfer in req_tdata. rsp_* then
//   gives its text one character per transfer: an optional '-', the integer
//   part without leading zeros, '.', and six fraction digits. rsp_tlast marks
//   the final character of each value. 0x80000000 reads as "-32768.000000".
//   Digits come from one shared divide-by-ten unit (a reciprocal multiply),
//   one digit a cycle: six fraction digits, then the integer digits.
//   The first character leaves only once every digit is worked out, and
//   req_tready is high only while the sequencer is idle. A stalled
//   receiver holds the output register and the sequencer in its output
//   states; the last character may still wait in the output register
//   while the next value is taken in. Reset (synchronous, active high)
//   drops any value in progress and empties the output register.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [fda_pkg::VALUE_W-1:0]    req_tdata,   // [31:0] value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [fda_pkg::RSP_W-1:0]      rsp_tdata,   // [6:0] char_out, [7] zero
   output logic                           rsp_tlast    // last
);
   import fda_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_FDIG,
      S_IDIG,
      S_SIGN,
      S_INT,
      S_DOT,
      S_FOUT
   } state_type;

   state_type                  state_ff, state_in;
   logic                       neg_ff, neg_in;
   logic [VALUE_W-1:0]         mag_ff, mag_in;
   logic [WORK_W-1:0]          work_ff, work_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic [DIGIT_W-1:0]         fdig_ff [FRAC_DIG];
   logic [DIGIT_W-1:0]         fdig_in [FRAC_DIG];
   logic [DIGIT_W-1:0]         idig_ff [INT_DIG];
   logic [DIGIT_W-1:0]         idig_in [INT_DIG];
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [CHAR_W-1:0]          rsp_char_ff, rsp_char_in;
   logic                       rsp_tlast_ff, rsp_tlast_in;

   // Shared arithmetic
   logic [35:0]                frac_prod;
   logic [39:0]                div_prod;
   logic [QUO_W-1:0]           quo;
   logic [WORK_W-1:0]          quo_x10;
   logic [WORK_W-1:0]          rem_full;
   logic [DIGIT_W-1:0]         rem;
   logic                       out_free;
   logic                       req_xfer;

   assign frac_prod = 36'(mag_ff[15:0]) * 36'(FRAC_SCALE);
   assign div_prod  = 40'(work_ff) * 40'(RECIP_TEN);
   assign quo       = div_prod[RECIP_SHIFT +: QUO_W];
   assign quo_x10   = {quo, 3'b000} + {2'b00, quo, 1'b0};
   assign rem_full  = work_ff - quo_x10;
   assign rem       = rem_full[DIGIT_W-1:0];

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      work_in       = work_ff;
      cnt_in        = cnt_ff;
      fdig_in       = fdig_ff;
      idig_in       = idig_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      // drop the held character once it has been taken
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               neg_in   = req_tdata[VALUE_W-1];
               mag_in   = req_tdata[VALUE_W-1] ? (VALUE_W'(0) - req_tdata) : req_tdata;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // scaled fraction, below 1000000
            work_in  = frac_prod[35:16];
            cnt_in   = 3'(FRAC_DIG - 1);
            state_in = S_FDIG;
         end
         S_FDIG: begin
            // fraction digits arrive least significant first
            fdig_in[cnt_ff] = rem;
            if (cnt_ff == 3'd0) begin
               work_in  = WORK_W'(mag_ff[31:16]);
               state_in = S_IDIG;
            end else begin
               work_in = WORK_W'(quo);
               cnt_in  = cnt_ff - 3'd1;
            end
         end
         S_IDIG: begin
            idig_in[cnt_ff] = rem;
            work_in         = WORK_W'(quo);
            // stop on a zero quotient or at the last digit slot; cnt then marks the leading digit
            if (quo == '0 || cnt_ff == 3'(INT_DIG - 1)) begin
               state_in = neg_ff ? S_SIGN : S_INT;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = CH_MINUS;
               rsp_tlast_in  = 1'b0;
               state_in      = S_INT;
            end
         end
         S_INT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = CH_ZERO + CHAR_W'(idig_ff[cnt_ff]);
               rsp_tlast_in  = 1'b0;
               if (cnt_ff == 3'd0) begin
                  state_in = S_DOT;
               end else begin
                  cnt_in = cnt_ff - 3'd1;
               end
            end
         end
         S_DOT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = CH_DOT;
               rsp_tlast_in  = 1'b0;
               cnt_in        = 3'd0;
               state_in      = S_FOUT;
            end
         end
         S_FOUT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_char_in   = CH_ZERO + CHAR_W'(fdig_ff[cnt_ff]);
               rsp_tlast_in  = (cnt_ff == 3'(FRAC_DIG - 1));
               if (cnt_ff == 3'(FRAC_DIG - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      // payload: no reset needed
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      work_ff      <= work_in;
      cnt_ff       <= cnt_in;
      fdig_ff      <= fdig_in;
      idig_ff      <= idig_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_tlast_ff;

`include "fixed_to_decimal_ascii_core_assert.svh"

   // a taken value keeps the sequencer busy
   `FDA_ASSERT_NEXT(a_busy_after_req, req_xfer, !req_tready)
   // the final character of a value is always a fraction digit
   `FDA_ASSERT_SAME(a_last_is_digit, rsp_tvalid && rsp_tlast,
                    rsp_tdata[6:0] >= CH_ZERO && rsp_tdata[6:0] <= CH_NINE)
   // digit pointers stay inside their stores
   `FDA_ASSERT_SAME(a_int_ptr, state_ff == S_INT || state_ff == S_IDIG,
                    cnt_ff <= 3'(INT_DIG - 1))
   `FDA_ASSERT_SAME(a_frac_ptr, state_ff == S_FOUT || state_ff == S_FDIG,
                    cnt_ff <= 3'(FRAC_DIG - 1))

endmodule

// ===== dv/fda_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fda_checker
// Watches both streams of the decimal text core, works out the text of each
// accepted value and compares every character transfer with it in order.
// ----------------------------------------------------------------------------
module fda_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [fda_pkg::VALUE_W-1:0] req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [fda_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        rsp_tlast,
   output int                          fail_count,
   output int                          pending
);
   import fda_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_type;

   text_char_type text_q[$];

   function automatic void push_char(input logic [CHAR_W-1:0] ch, input logic last);
      text_char_type tc;
      tc.ch   = ch;
      tc.last = last;
      text_q.push_back(tc);
   endfunction

   // Sign, integer digits without leading zeros, point, six fraction digits.
   function automatic void queue_text(input logic [VALUE_W-1:0] value);
      logic              neg;
      logic [31:0]       mag;
      logic [63:0]       scaled;
      int unsigned       rest;
      int unsigned       frac_dec;
      logic [DIGIT_W-1:0] int_digits[INT_DIG];
      logic [DIGIT_W-1:0] frac_digits[FRAC_DIG];
      int                n_int;
      neg    = value[VALUE_W-1];
      mag    = neg ? (32'd0 - value) : value;
      scaled = 64'(mag[15:0]) * 64'd1000000;
      frac_dec = 32'(scaled >> 16);
      if (neg) begin
         push_char(CH_MINUS, 1'b0);
      end
      rest  = 32'(mag[31:16]);
      n_int = 0;
      do begin
         int_digits[n_int] = DIGIT_W'(rest % 10);
         rest = rest / 10;
         n_int++;
      end while (rest != 0 && n_int < INT_DIG);
      for (int i = n_int - 1; i >= 0; i--) begin
         push_char(CH_ZERO + CHAR_W'(int_digits[i]), 1'b0);
      end
      push_char(CH_DOT, 1'b0);
      for (int i = FRAC_DIG - 1; i >= 0; i--) begin
         frac_digits[i] = DIGIT_W'(frac_dec % 10);
         frac_dec = frac_dec / 10;
      end
      for (int i = 0; i < FRAC_DIG; i++) begin
         push_char(CH_ZERO + CHAR_W'(frac_digits[i]), i == FRAC_DIG - 1);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         fail_count <= 0;
         pending    <= 0;
      end else begin
         // retire the oldest character first, then queue any new text
         if (rsp_tvalid && rsp_tready) begin
            if (text_q.size() == 0) begin
               fail_count <= fail_count + 1;
               $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                        $time, rsp_tdata[CHAR_W-1:0], rsp_tlast);
            end else begin
               want = text_q.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== want.ch || rsp_tlast !== want.last) begin
                  fail_count <= fail_count + 1;
                  $display("%0t: text mismatch: expected 0x%02h last %0b, actual 0x%02h last %0b",
                           $time, want.ch, want.last, rsp_tdata[CHAR_W-1:0], rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            queue_text(req_tdata);
         end
         pending <= text_q.size();
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives fixed-point values into the decimal text core, first a directed
// set of corner values, then random values of mixed shape, with random gaps
// on the input and random stalls on the output. The checker beside the core
// predicts and compares the text; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import fda_pkg::*;

   localparam int N_RANDOM    = 106;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 40;     // settling time after the last expected character

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tlast;

   int  fail_count;
   int  pending;
   int  cycle_count;
   bit  steady;         // while set, neither side idles

   fixed_to_decimal_ascii_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   fda_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 4 ns period: low half then high half
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Receiver: stall in about a third of cycles unless in the steady stretch.
   // Change at the falling edge so the core sees a settled tready.
   always @(negedge clock) begin
      if (steady) begin
         rsp_tready = 1'b1;
      end else begin
         rsp_tready = ($urandom_range(99) >= 32);
      end
   end

   // Offer one value and hold it until the transfer. On return the clock is
   // at a falling edge, so the next call may keep tvalid high without a
   // drop in between.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      // idle a cycle at a time with a chance of about a third
      while (!steady && $urandom_range(99) < 32) begin
         req_tvalid = 1'b0;
         req_tdata  = $urandom;         // noise on the bus while idle
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random values of mixed shape: full range, small magnitudes with either
   // sign, whole numbers, and values near the extremes.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(4))
         0, 1: begin
            v = $urandom;
         end
         2: begin
            v = {16'($urandom_range(0, 120)), 16'($urandom)};
            if ($urandom_range(1)) v = 32'd0 - v;
         end
         3: begin
            v = {16'($urandom), 16'h0000};
         end
         default: begin
            v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(0, 300)
                                  : 32'h7FFF_FFFF - $urandom_range(0, 300);
         end
      endcase
      return v;
   endfunction

   logic [VALUE_W-1:0] directed[$];

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      steady     = 1'b0;
      reset      = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Corners: zero, most negative, largest positive, smallest steps either
      // side of zero, negative with zero integer part, every integer width,
      // and fractions that round down from just under one.
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                   32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000,
                   32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_0001, 32'h0009_FFFF,
                   32'h000A_0000, 32'h0063_0000, 32'h0064_0000, 32'h03E7_0000,
                   32'h03E8_0000, 32'h270F_0000, 32'h2710_0000, 32'h7FFF_0000,
                   32'h8000_0001, 32'h8001_0000, 32'h5555_AAAA, 32'hAAAA_5555};
      foreach (directed[i]) send_value(directed[i]);

      // Random part; a stretch in the middle runs with no idling at all.
      for (int n = 0; n < N_RANDOM; n++) begin
         steady = (n >= 50 && n < 80);
         send_value(pick_value());
      end
      steady     = 1'b0;
      req_tvalid = 1'b0;

      // Drain: wait for every expected character, then let the core settle.
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
